>>> rtl/wlzss_pkg.sv
// ----------------------------------------------------------------------------
// wlzss_pkg
// shared types and constants of the word lzss stream decoder
// ----------------------------------------------------------------------------
`default_nettype none

package wlzss_pkg;

    localparam int WORD_W       = 16;
    localparam int WINDOW_DEPTH = 2048;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = WORD_W - PTR_W;
    localparam int LEFT_W       = 5;
    localparam logic [LEFT_W-1:0] GROUP_ITEMS = LEFT_W'(16);

    // item kinds
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // what one accepted item turns into for the result stage
    typedef struct packed {
        logic              emit;          // result carries a decoded word
        logic              from_mem;      // word comes from the history ring
        logic              hist_ok;       // ring entry has been written before
        logic [WORD_W-1:0] lit_word;      // literal word, zero otherwise
        logic [PTR_W-1:0]  raddr;         // ring read index for a copy
        logic [PTR_W-1:0]  waddr;         // ring write index for the word
        logic              copy_pending;
        logic              finished;
        logic              err;
    } step_t;

endpackage

`default_nettype wire

>>> rtl/wlzss_ram.sv
// ----------------------------------------------------------------------------
// wlzss_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module wlzss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/wlzss_ctrl.sv
// ----------------------------------------------------------------------------
// wlzss_ctrl
// stream parser: flag groups, tokens, copy length and ring pointer
// ----------------------------------------------------------------------------
`default_nettype none

module wlzss_ctrl
    import wlzss_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              op,
    input  wire logic [WORD_W-1:0] in_word,
    output step_t                  step
);

    logic [PTR_W-1:0]  wp_reg,    wp_next;
    logic              wrap_reg,  wrap_next;
    logic [WORD_W-1:0] flag_reg,  flag_next;
    logic [LEFT_W-1:0] left_reg,  left_next;
    logic              await_reg, await_next;
    logic [PTR_W-1:0]  dist_reg,  dist_next;
    logic [WORD_W-1:0] rem_reg,   rem_next;
    logic              done_reg,  done_next;

    logic [CNT_W-1:0]  tok_count;
    logic [PTR_W-1:0]  rd_idx;

    assign tok_count = in_word[WORD_W-1:PTR_W];
    assign rd_idx    = wp_reg - dist_reg;

    always_comb
    begin
        wp_next    = wp_reg;
        wrap_next  = wrap_reg;
        flag_next  = flag_reg;
        left_next  = left_reg;
        await_next = await_reg;
        dist_next  = dist_reg;
        rem_next   = rem_reg;
        done_next  = done_reg;

        step          = '0;
        step.raddr    = rd_idx;
        step.waddr    = wp_reg;
        // fill tracking: entries are written in pointer order from zero
        step.hist_ok  = wrap_reg || (rd_idx < wp_reg);

        if (done_reg)
        begin
            // after the end marker nothing changes
        end
        else if (op == OP_TICK)
        begin
            if (rem_reg != '0)
            begin
                step.emit     = 1'b1;
                step.from_mem = 1'b1;
                rem_next      = rem_reg - WORD_W'(1);
                wp_next       = wp_reg + PTR_W'(1);
            end
        end
        else if (rem_reg != '0)
        begin
            step.err = 1'b1;
        end
        else if (await_reg)
        begin
            await_next = 1'b0;
            if (in_word == '0 && dist_reg == '0)
            begin
                done_next = 1'b1;
            end
            else
            begin
                rem_next = in_word;
            end
        end
        else if (left_reg == '0)
        begin
            flag_next = in_word;
            left_next = GROUP_ITEMS;
        end
        else
        begin
            flag_next = {flag_reg[WORD_W-2:0], 1'b0};
            left_next = left_reg - LEFT_W'(1);
            if (!flag_reg[WORD_W-1])
            begin
                step.emit     = 1'b1;
                step.lit_word = in_word;
                wp_next       = wp_reg + PTR_W'(1);
            end
            else
            begin
                dist_next = in_word[PTR_W-1:0];
                if (tok_count == '0)
                begin
                    await_next = 1'b1;
                end
                else
                begin
                    rem_next = {{PTR_W{1'b0}}, tok_count};
                end
            end
        end

        if (step.emit && (wp_reg == '1))
        begin
            wrap_next = 1'b1;
        end

        step.copy_pending = (rem_next != '0);
        step.finished     = done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            wrap_reg  <= 1'b0;
            flag_reg  <= '0;
            left_reg  <= '0;
            await_reg <= 1'b0;
            dist_reg  <= '0;
            rem_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            wp_reg    <= wp_next;
            wrap_reg  <= wrap_next;
            flag_reg  <= flag_next;
            left_reg  <= left_next;
            await_reg <= await_next;
            dist_reg  <= dist_next;
            rem_reg   <= rem_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/word_lzss_stream_decoder.sv
// ----------------------------------------------------------------------------
// word_lzss_stream_decoder
// lzss decompressor for a stream of 16-bit words with a 2048-word history
// ----------------------------------------------------------------------------
// result: a result beat is offered in the cycle after its item beat is taken
// throughput: one item per cycle if not stalled, set by the single read and
//   single write port of the history ram (read at accept, write as the result leaves)
// reset: control state clears at once, no clearing pass over the ram;
//   entries never written read as zero through the fill tracking
// ----------------------------------------------------------------------------
`default_nettype none

module word_lzss_stream_decoder
    import wlzss_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // item channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              op,
    input  wire logic [WORD_W-1:0] in_word,
    // result channel
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic                   out_valid,
    output logic      [WORD_W-1:0] out_word,
    output logic                   copy_pending,
    output logic                   finished,
    output logic                   protocol_error
);

    // handshakes
    logic in_accept;
    logic res_accept;

    // decoded item from the parser
    step_t step;

    // result stage
    logic              s1_valid_reg, s1_valid_next;
    step_t             s1_step_reg;
    logic              fwd_reg;        // read collided with a write in flight
    logic [WORD_W-1:0] fwd_data_reg;   // last word written to the ring
    logic [WORD_W-1:0] s1_word;

    // ram ports
    logic              ram_we;
    logic              ram_re;
    logic [WORD_W-1:0] ram_rdata;
    logic              fwd_hit;

    // the result register frees up in the same cycle it is taken
    assign in_ready   = !s1_valid_reg || res_ready;
    assign in_accept  = in_valid && in_ready;
    assign res_accept = s1_valid_reg && res_ready;

    wlzss_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .op      (op),
        .in_word (in_word),
        .step    (step)
    );

    // ring write happens as the result beat leaves, once per emitted word
    assign ram_we = res_accept && s1_step_reg.emit;
    assign ram_re = in_accept && step.from_mem;

    // a copy with distance one reads the entry the previous word is writing now
    assign fwd_hit = ram_re && ram_we && (s1_step_reg.waddr == step.raddr);

    wlzss_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_step_reg.waddr),
        .wdata (s1_word),
        .re    (ram_re),
        .raddr (step.raddr),
        .rdata (ram_rdata)
    );

    // word selection: literal, forwarded write, ring data, or an unwritten entry
    always_comb
    begin
        if (!s1_step_reg.from_mem)
        begin
            s1_word = s1_step_reg.lit_word;
        end
        else if (fwd_reg)
        begin
            s1_word = fwd_data_reg;
        end
        else if (s1_step_reg.hist_ok)
        begin
            s1_word = ram_rdata;
        end
        else
        begin
            s1_word = '0;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (res_accept)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (in_accept)
            begin
                fwd_reg <= fwd_hit;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_step_reg <= step;
        end
        if (ram_we)
        begin
            fwd_data_reg <= s1_word;
        end
    end

    assign res_valid      = s1_valid_reg;
    assign out_valid      = s1_step_reg.emit;
    assign out_word       = s1_word;
    assign copy_pending   = s1_step_reg.copy_pending;
    assign finished       = s1_step_reg.finished;
    assign protocol_error = s1_step_reg.err;

    // forwarding is only ever armed for a copy word
    a_fwd_copy_only : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && fwd_reg) |-> s1_step_reg.from_mem)
        else $error("forwarding armed for a non-copy result");

    // an ignored data word never produces a decoded word
    a_err_no_word : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_step_reg.err) |-> (!out_valid && out_word == '0))
        else $error("protocol error beat carries a word");

    // the end marker state is sticky across result beats
    a_finished_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        (res_accept && finished) |=> (!s1_valid_reg || finished))
        else $error("finished dropped after the end marker");

    // a ring read is only issued while the result stage can take the word
    a_read_slot : assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (!s1_valid_reg || res_ready))
        else $error("ring read issued while the result stage is stalled");

endmodule

`default_nettype wire
